// ===== design/eesch_pkg.sv =====
// ----------------------------------------------------------------------------
// eesch_pkg
// shared types and codes of the earliest event scheduler
// ----------------------------------------------------------------------------
package eesch_pkg;

  localparam int PORT_TIME_W = 64;
  localparam int PORT_ID_W   = 4;

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_STEP    = 2'd1;
  localparam logic [1:0] FUNC_RESCHED = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_BACK    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } eesch_state_t;

endpackage

// ===== design/earliest_event_scheduler_unit.sv =====
// add, reschedule and the unused code go from acceptance to S_DONE, which raises out_valid
// once the output register is free; step scans the table in S_SCAN first, unless it is empty
// a new transaction is taken only in S_IDLE, after the last result is loaded into the output
// register; the time table is read one entry a cycle by a single comparator during step
// reset: synchronous active-low rst_n clears the table count, scheduled bits and current time
// ----------------------------------------------------------------------------
// earliest_event_scheduler_unit
// keeps a table of event times, adds and reschedules entries and selects the
// earliest scheduled entry with a sequential compare over the table memory
// ----------------------------------------------------------------------------
module earliest_event_scheduler_unit
  import eesch_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [PORT_ID_W-1:0]   in_entry_id,
  input  logic [PORT_TIME_W-1:0] in_new_time,
  input  logic                   in_unscheduled,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_status,
  output logic [PORT_ID_W-1:0]   out_result_id,
  output logic [PORT_TIME_W-1:0] out_result_time,
  output logic [PORT_TIME_W-1:0] out_current_time
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EW    = (CNT_W > PORT_ID_W) ? CNT_W : PORT_ID_W;

  eesch_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [ENTRIES-1:0]   sched_r, sched_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_time_r, best_time_nxt;

  logic [2:0]           res_status_r, res_status_nxt;
  logic [PORT_ID_W-1:0] res_id_r, res_id_nxt;
  logic [TIME_BITS-1:0] res_time_r, res_time_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic [PORT_ID_W-1:0]   out_result_id_r, out_result_id_nxt;
  logic [PORT_TIME_W-1:0] out_result_time_r, out_result_time_nxt;
  logic [PORT_TIME_W-1:0] out_current_time_r, out_current_time_nxt;

  logic [TIME_BITS-1:0] time_mem_r [ENTRIES];
  logic [TIME_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;

  logic [TIME_BITS-1:0] in_time;
  logic [IDX_W-1:0]     eid_idx;
  logic [IDX_W-1:0]     add_idx;
  logic                 cmp_hit;

  assign in_time = TIME_BITS'(in_new_time);
  assign eid_idx = IDX_W'(in_entry_id);
  assign add_idx = count_r[IDX_W-1:0];
  assign rd_addr = scan_idx_r[IDX_W-1:0];
  assign cmp_hit = cmp_vld_r && sched_r[cmp_idx_r] && (!found_r || (rd_data_r < best_time_r));

  always_comb begin
    state_nxt            = state_r;
    count_nxt            = count_r;
    now_nxt              = now_r;
    sched_nxt            = sched_r;
    scan_idx_nxt         = scan_idx_r;
    cmp_vld_nxt          = 1'b0;
    cmp_idx_nxt          = scan_idx_r[IDX_W-1:0];
    found_nxt            = found_r;
    best_idx_nxt         = best_idx_r;
    best_time_nxt        = best_time_r;
    res_status_nxt       = res_status_r;
    res_id_nxt           = res_id_r;
    res_time_nxt         = res_time_r;
    out_valid_nxt        = out_valid_r;
    out_status_nxt       = out_status_r;
    out_result_id_nxt    = out_result_id_r;
    out_result_time_nxt  = out_result_time_r;
    out_current_time_nxt = out_current_time_r;
    mem_we               = 1'b0;
    mem_wa               = add_idx;
    in_ready             = 1'b0;

    // running minimum over the registered table read
    if (cmp_hit) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = cmp_idx_r;
      best_time_nxt = rd_data_r;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_time_nxt   = '0;
          state_nxt      = S_DONE;
          case (in_func)
            FUNC_ADD: begin
              if (count_r == CNT_W'(ENTRIES)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_wa             = add_idx;
                sched_nxt[add_idx] = !in_unscheduled;
                res_id_nxt         = PORT_ID_W'(count_r);
                count_nxt          = count_r + 1'b1;
              end
            end
            FUNC_STEP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NONE;
              end else begin
                state_nxt    = S_SCAN;
                scan_idx_nxt = '0;
                found_nxt    = 1'b0;
              end
            end
            FUNC_RESCHED: begin
              if (EW'(in_entry_id) >= EW'(count_r)) begin
                res_status_nxt = ST_UNKNOWN;
              end else if (in_unscheduled) begin
                sched_nxt[eid_idx] = 1'b0;
              end else if (in_time < now_r) begin
                res_status_nxt = ST_BACK;
              end else begin
                mem_we             = 1'b1;
                mem_wa             = eid_idx;
                sched_nxt[eid_idx] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_idx_r != count_r) begin
          cmp_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
          if (found_nxt) begin
            res_status_nxt = ST_OK;
            res_id_nxt     = PORT_ID_W'(best_idx_nxt);
            res_time_nxt   = best_time_nxt;
            now_nxt        = best_time_nxt;
          end else begin
            res_status_nxt = ST_NONE;
            res_id_nxt     = '0;
            res_time_nxt   = '0;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = res_status_r;
          out_result_id_nxt    = res_id_r;
          out_result_time_nxt  = PORT_TIME_W'(res_time_r);
          out_current_time_nxt = PORT_TIME_W'(now_r);
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      now_r       <= '0;
      sched_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      sched_r     <= sched_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r          <= cmp_idx_nxt;
    best_idx_r         <= best_idx_nxt;
    best_time_r        <= best_time_nxt;
    res_status_r       <= res_status_nxt;
    res_id_r           <= res_id_nxt;
    res_time_r         <= res_time_nxt;
    out_status_r       <= out_status_nxt;
    out_result_id_r    <= out_result_id_nxt;
    out_result_time_r  <= out_result_time_nxt;
    out_current_time_r <= out_current_time_nxt;
  end

  // time table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem_r[mem_wa] <= in_time;
    end
    rd_data_r <= time_mem_r[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_id    = out_result_id_r;
  assign out_result_time  = out_result_time_r;
  assign out_current_time = out_current_time_r;

endmodule

// ===== design/eesch_checker.sv =====
// ----------------------------------------------------------------------------
// eesch_checker
// port-level checks of the earliest event scheduler result channel
// ----------------------------------------------------------------------------
module eesch_checker
  import eesch_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [2:0]             out_status,
  input logic [PORT_ID_W-1:0]   out_result_id,
  input logic [PORT_TIME_W-1:0] out_result_time,
  input logic [PORT_TIME_W-1:0] out_current_time
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_result_id) && $stable(out_result_time) && $stable(out_current_time))
    else $error("result transaction changed while stalled");

  // a failed operation reports no selected time
  a_fail_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_time == '0)
    else $error("failed transaction reports a time");

  // full table assigns no id
  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_result_id == '0)
    else $error("full table reports an id");

  // a step that selects a time moves the current time to it
  a_step_now: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) && (out_result_time != '0) |->
      out_current_time == out_result_time)
    else $error("current time differs from selected time");

endmodule

bind earliest_event_scheduler_unit eesch_checker u_eesch_checker (.*);

// ===== sim/earliest_event_scheduler_unit_test.sv =====
// ----------------------------------------------------------------------------
// earliest_event_scheduler_unit_test
// drives add, step, reschedule and unused-code requests into the scheduler under random
// valid and ready gaps, predicts every response from a local copy of the
// event table and compares all response fields in order
// ----------------------------------------------------------------------------
module earliest_event_scheduler_unit_test
  import eesch_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NUM_ENTRIES = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [63:0] TIME_MAX   = '1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  id;
    logic [63:0] t;
    logic        unsch;
  } sched_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  rid;
    logic [63:0] rtime;
    logic [63:0] now;
  } sched_resp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_func = FUNC_ADD;
  logic [PORT_ID_W-1:0]   in_entry_id = '0;
  logic [PORT_TIME_W-1:0] in_new_time = '0;
  logic                   in_unscheduled = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             out_status;
  logic [PORT_ID_W-1:0]   out_result_id;
  logic [PORT_TIME_W-1:0] out_result_time;
  logic [PORT_TIME_W-1:0] out_current_time;

  logic [63:0] sched_time [NUM_ENTRIES];
  logic        sched_on [NUM_ENTRIES];
  int          sched_count = 0;
  logic [63:0] sched_now = '0;

  sched_resp_t pending_responses [$];
  sched_req_t  seen_req;
  sched_resp_t want;
  int          accept_count = 0;
  int          err_count = 0;
  int          status_seen [8];
  bit          hold_rx = 1'b0;
  bit          calm = 1'b0;

  earliest_event_scheduler_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_id      (in_entry_id),
    .in_new_time      (in_new_time),
    .in_unscheduled   (in_unscheduled),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_result_time  (out_result_time),
    .out_current_time (out_current_time)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit find_earliest(output int idx);
    bit found;
    found = 1'b0;
    idx = 0;
    for (int i = 0; i < sched_count; i++) begin
      if (sched_on[i] && (!found || sched_time[i] < sched_time[idx])) begin
        idx = i;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic sched_resp_t predict_response(sched_req_t r);
    sched_resp_t p;
    int pick;
    p = '0;
    case (r.func)
      FUNC_ADD: begin
        if (sched_count >= NUM_ENTRIES) begin
          p.status = ST_FULL;
        end else begin
          sched_time[sched_count] = r.t;
          sched_on[sched_count] = !r.unsch;
          p.rid = 4'(sched_count);
          sched_count++;
        end
      end
      FUNC_STEP: begin
        if (!find_earliest(pick)) begin
          p.status = ST_NONE;
        end else begin
          p.rid = 4'(pick);
          p.rtime = sched_time[pick];
          sched_now = sched_time[pick];
        end
      end
      FUNC_RESCHED: begin
        if (int'(r.id) >= sched_count) begin
          p.status = ST_UNKNOWN;
        end else if (r.unsch) begin
          sched_on[r.id] = 1'b0;
        end else if (r.t < sched_now) begin
          p.status = ST_BACK;
        end else begin
          sched_time[r.id] = r.t;
          sched_on[r.id] = 1'b1;
        end
      end
      default: ;
    endcase
    p.now = sched_now;
    return p;
  endfunction

  function automatic logic [63:0] later_time();
    int r;
    r = $urandom_range(99);
    if (r < 30) return sched_now + 64'($urandom_range(3));
    if (r < 80) return sched_now + 64'($urandom_range(1000));
    if (r < 95) return sched_now + {32'd0, $urandom};
    return rand64();
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $error("response with no request outstanding: status %0d", out_status);
          err_count++;
        end else begin
          want = pending_responses.pop_front();
          status_seen[want.status]++;
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            err_count++;
          end
          if (out_result_id !== want.rid) begin
            $error("result_id mismatch: expected %0d, actual %0d", want.rid, out_result_id);
            err_count++;
          end
          if (out_result_time !== want.rtime) begin
            $error("result_time mismatch: expected %0h, actual %0h",
                   want.rtime, out_result_time);
            err_count++;
          end
          if (out_current_time !== want.now) begin
            $error("current_time mismatch: expected %0h, actual %0h",
                   want.now, out_current_time);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen_req.func = in_func;
        seen_req.id = in_entry_id;
        seen_req.t = in_new_time;
        seen_req.unsch = in_unscheduled;
        pending_responses.push_back(predict_response(seen_req));
        accept_count++;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_rx && (calm || $urandom_range(99) >= 36);
  end

  task automatic send_req(input logic [1:0] f, input logic [3:0] id,
                          input logic [63:0] t, input logic u);
    int seen;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_entry_id <= id;
    in_new_time <= t;
    in_unscheduled <= u;
    seen = accept_count;
    wait (accept_count != seen);
    @(negedge clk);
  endtask

  task automatic send_random_req(input int add_pct);
    int roll;
    int pick;
    logic [63:0] t;
    roll = $urandom_range(99);
    if (roll < add_pct) begin
      roll = $urandom_range(9);
      t = (roll < 7) ? later_time() : (roll < 9) ? rand64() : 64'($urandom_range(50));
      send_req(FUNC_ADD, 4'($urandom_range(15)), t, $urandom_range(9) == 0);
    end else if (roll < 45) begin
      send_req(FUNC_STEP, 4'($urandom_range(15)), rand64(), 1'($urandom));
    end else if (roll < 65) begin
      if (find_earliest(pick))
        send_req(FUNC_RESCHED, 4'(pick), later_time(), 1'b0);
      else
        send_req(FUNC_STEP, 4'($urandom_range(15)), rand64(), 1'($urandom));
    end else if (roll < 87 && sched_count > 0) begin
      pick = $urandom_range(sched_count - 1);
      if (roll < 80 || sched_now == 0)
        send_req(FUNC_RESCHED, 4'(pick), later_time(), $urandom_range(9) == 0);
      else
        send_req(FUNC_RESCHED, 4'(pick), sched_now - 64'd1 - (rand64() % sched_now), 1'b0);
    end else if (roll < 96) begin
      send_req(FUNC_RESCHED, 4'($urandom_range(15)), rand64(), 1'($urandom));
    end else begin
      send_req(FUNC_UNUSED, 4'($urandom_range(15)), rand64(), 1'($urandom));
    end
  endtask

  task automatic test_empty_table();
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_RESCHED, 4'd0, 64'd10, 1'b0);
    send_req(FUNC_RESCHED, 4'd15, TIME_MAX, 1'b1);
    send_req(FUNC_UNUSED, 4'd15, TIME_MAX, 1'b1);
  endtask

  task automatic test_add_and_step();
    send_req(FUNC_ADD, 4'd9, 64'd100, 1'b0);
    send_req(FUNC_ADD, 4'd0, 64'd100, 1'b0);
    send_req(FUNC_ADD, 4'd0, TIME_MAX, 1'b0);
    send_req(FUNC_ADD, 4'd0, 64'd0, 1'b1);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_RESCHED, 4'd0, 64'd0, 1'b1);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_RESCHED, 4'd1, 64'd99, 1'b0);
    send_req(FUNC_RESCHED, 4'd1, 64'd100, 1'b0);
    send_req(FUNC_RESCHED, 4'd1, TIME_MAX, 1'b0);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_ADD, 4'd0, 64'd5, 1'b0);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_RESCHED, 4'd3, 64'd5, 1'b0);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
    send_req(FUNC_RESCHED, 4'd7, 64'd50, 1'b0);
  endtask

  task automatic test_idle_table();
    for (int i = 1; i < 5; i++)
      send_req(FUNC_RESCHED, 4'(i), 64'd0, 1'b1);
    send_req(FUNC_STEP, 4'd0, 64'd0, 1'b0);
  endtask

  task automatic test_random_growth();
    repeat (700) send_random_req(2);
  endtask

  task automatic test_table_full();
    while (sched_count < NUM_ENTRIES)
      send_req(FUNC_ADD, 4'd0, later_time(), 1'b0);
    send_req(FUNC_ADD, 4'd15, TIME_MAX, 1'b1);
    send_req(FUNC_ADD, 4'd0, 64'd0, 1'b0);
  endtask

  task automatic test_receiver_hold();
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      begin
        repeat (30) send_random_req(0);
      end
    join
  endtask

  task automatic test_random_steady();
    calm = 1'b1;
    repeat (250) send_random_req(4);
    calm = 1'b0;
    repeat (950) send_random_req(4);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_add_and_step();
    test_idle_table();
    test_random_growth();
    test_table_full();
    test_receiver_hold();
    test_random_steady();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("%0d transactions checked: %0d ok, %0d nothing scheduled, %0d unknown id,",
             accept_count, status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_UNKNOWN]);
    $display("%0d time going back, %0d table full, one 400 cycle receiver hold",
             status_seen[ST_BACK], status_seen[ST_FULL]);
    if (err_count == 0) begin
      $display("PASS earliest_event_scheduler_unit");
    end else begin
      $display("FAIL earliest_event_scheduler_unit");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL earliest_event_scheduler_unit");
    $finish;
  end

endmodule

// ===== files.f =====
design/eesch_pkg.sv
design/earliest_event_scheduler_unit.sv
design/eesch_checker.sv
sim/earliest_event_scheduler_unit_test.sv
